FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

`define ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, expr)
`define ASSERT_IMPLIES(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/iirlp_pkg.sv
// ----------------------------------------------------------------------------
// iirlp_pkg
// constants, types and coefficient table of the sixth-order iir lowpass
// ----------------------------------------------------------------------------
`default_nettype none

package iirlp_pkg;

	localparam int DIGIT_W   = 16;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 28;
	localparam int N_TAPS    = 6;
	localparam int TAP_W     = 3;
	localparam int TERM_W    = 4;

	typedef logic [TERM_W-1:0]        term_t;
	typedef logic [TAP_W-1:0]         tap_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	// terms 0..6 feedforward, 7..12 feedback
	localparam term_t FIRST_FB_TERM = TERM_W'(7);
	localparam term_t LAST_TERM     = TERM_W'(12);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_ROUND,
		ST_WRITE
	} state_t;

	// q4.28 coefficients, feedforward taps symmetric
	function automatic coef_t coef_of(input term_t t);
		coef_t c;
		case (t)
			TERM_W'(0):  c = 32'sd6166897;
			TERM_W'(1):  c = -32'sd1480556;
			TERM_W'(2):  c = 32'sd9705716;
			TERM_W'(3):  c = 32'sd996008;
			TERM_W'(4):  c = 32'sd9705716;
			TERM_W'(5):  c = -32'sd1480556;
			TERM_W'(6):  c = 32'sd6166897;
			TERM_W'(7):  c = -32'sd766754857;
			TERM_W'(8):  c = 32'sd1048854733;
			TERM_W'(9):  c = -32'sd809714999;
			TERM_W'(10): c = 32'sd372640353;
			TERM_W'(11): c = -32'sd94156582;
			TERM_W'(12): c = 32'sd10476016;
			default:     c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/iir_lowpass_order6.sv
// ----------------------------------------------------------------------------
// iir_lowpass_order6
// Sixth-order direct-form-I lowpass for a respiration signal, fixed point.
// Input channel: in_valid / in_stall with sample_in; a request is taken at a
// rising edge with in_valid high and in_stall low. Output channel: out_valid /
// out_stall with sample_out, one result per request, in order.
// The thirteen products share one 32 x 17 bit multiplier fed one 16-bit digit
// of the data word per cycle, least significant digit first. A feedforward
// term has ceil(SAMPLE_WIDTH/16) digits, a feedback term
// ceil((SAMPLE_WIDTH+FRAC_BITS)/16) digits; each product is then accumulated,
// and rounding and the output write follow the last term. No new request is
// taken before the previous result is written; in_stall is high for the
// whole computation.
// Reset clears both sample histories and the control state; no result is
// pending afterwards. While out_stall holds a result, the next result waits
// in the write step and the filter takes no new request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iir_lowpass_order6 #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	import iirlp_pkg::*;

	localparam int HIST_W = SAMPLE_WIDTH + FRAC_BITS;
	localparam int NDX    = (SAMPLE_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int NDY    = (HIST_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DSR_W  = NDY * DIGIT_W;
	localparam int P_W    = COEF_W + DIGIT_W + 1;
	localparam int PX_W   = P_W + NDX * DIGIT_W;
	localparam int PY_W   = P_W + DSR_W;
	localparam int ACC_W  = COEF_W + SAMPLE_WIDTH + 8;
	localparam int DIG_W  = $clog2(NDY);
	localparam int R_HIST = COEF_FRAC - FRAC_BITS;

	localparam logic signed [ACC_W-1:0] HALF_HIST = {{(ACC_W-1){1'b0}}, 1'b1} << (R_HIST - 1);
	localparam logic signed [ACC_W-1:0] HALF_OUT  = {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);

	state_t state_q, state_d;

	term_t                           term_q;
	logic [DIG_W-1:0]                dig_q;
	logic [DSR_W-1:0]                dsr_q;
	logic signed [P_W-1:0]           p_q;
	logic [DSR_W-1:0]                l_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [SAMPLE_WIDTH-1:0]  x_q;
	logic signed [SAMPLE_WIDTH-1:0]  xh_q [N_TAPS];
	logic signed [HIST_W-1:0]        yh_q [N_TAPS];
	logic signed [SAMPLE_WIDTH-1:0]  y_out_q;
	logic signed [SAMPLE_WIDTH-1:0]  sample_out_q;
	logic                            out_valid_q;

	logic                            in_accept;
	logic                            out_accept;
	logic                            is_fb;
	logic                            last_dig;
	logic [DIG_W-1:0]                nd_m1;
	term_t                           term_nx;
	term_t                           tap_x_full;
	term_t                           tap_y_full;
	logic [DSR_W-1:0]                load_val;
	coef_t                           coef;
	logic signed [DIGIT_W:0]         digit;
	logic signed [P_W-1:0]           mprod;
	logic signed [P_W-1:0]           psum;
	logic signed [PX_W-1:0]          prod_x;
	logic signed [PY_W-1:0]          prod_y;
	logic signed [PY_W-1:0]          prod_y_sh;
	logic signed [ACC_W-1:0]         acc_nx;
	logic signed [ACC_W-1:0]         hist_rnd;
	logic signed [ACC_W-1:0]         hist_sh;
	logic signed [ACC_W-1:0]         out_rnd;
	logic signed [ACC_W-1:0]         out_sh;
	logic signed [HIST_W-1:0]        y_hist;
	logic signed [SAMPLE_WIDTH-1:0]  y_out;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_accept = out_valid_q && !out_stall;

	// operand select for the next term
	assign term_nx    = term_q + 1'b1;
	assign tap_x_full = term_nx - TERM_W'(1);
	assign tap_y_full = term_nx - FIRST_FB_TERM;

	always_comb begin
		if (state_q == ST_IDLE) begin
			load_val = DSR_W'(sample_in);
		end else if (term_nx < FIRST_FB_TERM) begin
			load_val = DSR_W'(xh_q[tap_x_full[TAP_W-1:0]]);
		end else begin
			load_val = DSR_W'(yh_q[tap_y_full[TAP_W-1:0]]);
		end
	end

	// digit-serial multiply, low digits unsigned, top digit signed
	assign is_fb    = (term_q >= FIRST_FB_TERM);
	assign nd_m1    = is_fb ? DIG_W'(NDY - 1) : DIG_W'(NDX - 1);
	assign last_dig = (dig_q == nd_m1);
	assign coef     = coef_of(term_q);
	assign digit    = $signed({last_dig & dsr_q[DIGIT_W-1], dsr_q[DIGIT_W-1:0]});
	assign mprod    = coef * digit;
	assign psum     = p_q + mprod;

	assign prod_x    = $signed({p_q, l_q[DSR_W-1 -: NDX*DIGIT_W]});
	assign prod_y    = $signed({p_q, l_q});
	assign prod_y_sh = prod_y >>> FRAC_BITS;

	always_comb begin
		if (is_fb) begin
			acc_nx = acc_q - $signed(prod_y_sh[ACC_W-1:0]);
		end else begin
			acc_nx = acc_q + ACC_W'(prod_x);
		end
	end

	// round half up, then saturate
	assign hist_rnd = acc_q + HALF_HIST;
	assign hist_sh  = hist_rnd >>> R_HIST;
	assign out_rnd  = acc_q + HALF_OUT;
	assign out_sh   = out_rnd >>> COEF_FRAC;

	always_comb begin
		if ((&hist_sh[ACC_W-1:HIST_W-1]) || !(|hist_sh[ACC_W-1:HIST_W-1])) begin
			y_hist = hist_sh[HIST_W-1:0];
		end else if (hist_sh[ACC_W-1]) begin
			y_hist = {1'b1, {(HIST_W-1){1'b0}}};
		end else begin
			y_hist = {1'b0, {(HIST_W-1){1'b1}}};
		end
	end

	always_comb begin
		if ((&out_sh[ACC_W-1:SAMPLE_WIDTH-1]) || !(|out_sh[ACC_W-1:SAMPLE_WIDTH-1])) begin
			y_out = out_sh[SAMPLE_WIDTH-1:0];
		end else if (out_sh[ACC_W-1]) begin
			y_out = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			y_out = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (last_dig) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (term_q == LAST_TERM) begin
					state_d = ST_ROUND;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_ROUND: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!(out_valid_q && out_stall)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control, histories and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q      <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N_TAPS; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						term_q <= '0;
						dig_q  <= '0;
					end
				end
				ST_MUL: begin
					dig_q <= dig_q + 1'b1;
				end
				ST_ACC: begin
					if (term_q != LAST_TERM) begin
						term_q <= term_nx;
						dig_q  <= '0;
					end
				end
				ST_ROUND: begin
					xh_q[0] <= x_q;
					yh_q[0] <= y_hist;
					for (int i = 1; i < N_TAPS; i++) begin
						xh_q[i] <= xh_q[i-1];
						yh_q[i] <= yh_q[i-1];
					end
				end
				default: begin
				end
			endcase

			if (state_q == ST_WRITE && !(out_valid_q && out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_accept) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					x_q   <= sample_in;
					acc_q <= '0;
					dsr_q <= load_val;
					p_q   <= '0;
				end
			end
			ST_MUL: begin
				dsr_q <= {{DIGIT_W{1'b0}}, dsr_q[DSR_W-1:DIGIT_W]};
				p_q   <= psum >>> DIGIT_W;
				l_q   <= {psum[DIGIT_W-1:0], l_q[DSR_W-1:DIGIT_W]};
			end
			ST_ACC: begin
				acc_q <= acc_nx;
				dsr_q <= load_val;
				p_q   <= '0;
			end
			ST_ROUND: begin
				y_out_q <= y_out;
			end
			ST_WRITE: begin
				if (!(out_valid_q && out_stall)) begin
					sample_out_q <= y_out_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_ALWAYS(a_term_range, term_q <= LAST_TERM)
	`ASSERT_IMPLIES(a_digit_range, state_q == ST_MUL, dig_q <= nd_m1)
	`ASSERT_NEXT(a_request_starts, in_accept, state_q == ST_MUL && term_q == '0)
	`ASSERT_IMPLIES(a_round_after_last, state_q == ST_ROUND, $past(state_q) == ST_ACC && $past(term_q) == LAST_TERM)
	`ASSERT_NEXT(a_write_waits, state_q == ST_WRITE && out_valid_q && out_stall, state_q == ST_WRITE)

endmodule

`default_nettype wire

FILE: test/iir_lowpass_order6_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_lowpass_order6_test
// Self-checking bench for the sixth-order fixed-point iir lowpass. A bit-exact
// predictor of the filter computes each expected sample as its request is
// taken; a monitor compares every output in order. Directed extremes and
// long full-scale steps are followed by segmented random signals under
// several idle/stall mixes, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------

module iir_lowpass_order6_test;

	localparam int  SW          = 24;
	localparam int  HIST_FRAC   = 16;
	localparam int  ACC_FRAC    = 28;
	localparam int  N_HIST      = 6;
	localparam int  MAX_REPORTS = 10;
	localparam int  TAIL_CYCLES = 100;
	localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] S_MIN = -24'sh800000;

	localparam longint B_COEF [4] = '{64'sd6166897, -64'sd1480556, 64'sd9705716, 64'sd996008};
	localparam longint A_COEF [N_HIST] = '{-64'sd766754857, 64'sd1048854733, -64'sd809714999,
		64'sd372640353, -64'sd94156582, 64'sd10476016};

	typedef enum int {
		SEG_NOISE,
		SEG_HOLD,
		SEG_EXTREME,
		SEG_RAMP,
		SEG_SMALL
	} segment_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SW-1:0] sample_in;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [SW-1:0] sample_out;

	longint x_delay [N_HIST];
	longint y_delay [N_HIST];
	logic signed [SW-1:0] expected_samples [$];

	int send_idle_pct;
	int stall_pct;
	int hold_left;
	int requests_sent;
	int results_checked;
	int mismatches;
	bit extreme_high;

	iir_lowpass_order6 DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("Verification failed");
		$finish;
	end

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// one filter update: accumulate at 28 fraction bits, round, saturate, shift delays
	function automatic logic signed [SW-1:0] filter_step(input logic signed [SW-1:0] s);
		longint acc;
		longint xs;
		longint frac;
		longint y_new;
		longint y_int;
		int bi;
		xs = longint'(s);
		acc = B_COEF[0] * xs;
		for (int k = 1; k <= N_HIST; k++) begin
			bi = (k <= 3) ? k : N_HIST - k;
			acc += B_COEF[bi] * x_delay[k-1];
			frac = y_delay[k-1] & longint'(64'hFFFF);
			acc -= A_COEF[k-1] * (y_delay[k-1] >>> HIST_FRAC)
				+ ((A_COEF[k-1] * frac) >>> HIST_FRAC);
		end
		y_new = clamp((acc + (longint'(1) <<< (ACC_FRAC - HIST_FRAC - 1)))
			>>> (ACC_FRAC - HIST_FRAC), SW + HIST_FRAC);
		y_int = clamp((acc + (longint'(1) <<< (ACC_FRAC - 1))) >>> ACC_FRAC, SW);
		for (int k = N_HIST - 1; k > 0; k--) begin
			x_delay[k] = x_delay[k-1];
			y_delay[k] = y_delay[k-1];
		end
		x_delay[0] = xs;
		y_delay[0] = y_new;
		return y_int[SW-1:0];
	endfunction

	// receiver: random stall, or a counted hold-off when one is requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected output sample_out=%0d", $realtime, sample_out);
			end else begin
				if (sample_out !== expected_samples[0]) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: sample_out expected %0d got %0d", $realtime,
							expected_samples[0], sample_out);
				end
				void'(expected_samples.pop_front());
				results_checked++;
			end
		end
	end

	task automatic send_sample(input logic signed [SW-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			sample_in = SW'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample_in = v;
		do
			@(posedge clk);
		while (in_stall);
		expected_samples.push_back(filter_step(v));
		requests_sent++;
	endtask

	task automatic wait_drain;
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed;
		logic signed [SW-1:0] vals [$];
		send_idle_pct = 0;
		stall_pct = 0;
		vals = '{S_MAX, 24'sd0, 24'sd0, 24'sd0, 24'sd0, S_MIN, 24'sd0, 24'sd0, 24'sd0,
			24'sd1, -24'sd1};
		for (int i = 0; i < 7; i++)
			vals.push_back(S_MIN);
		for (int i = 0; i < 7; i++)
			vals.push_back(S_MAX);
		foreach (vals[i])
			send_sample(vals[i]);
	endtask

	// long full-scale steps drive the overshoot into saturation
	task automatic test_saturation;
		send_idle_pct = 10;
		stall_pct = 10;
		for (int i = 0; i < 100; i++)
			send_sample(S_MIN);
		for (int i = 0; i < 100; i++)
			send_sample(S_MAX);
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_in_pct);
		segment_kind_t kind;
		int seg_len;
		int r;
		int sent;
		logic signed [SW-1:0] level;
		logic signed [SW-1:0] step;
		logic signed [SW-1:0] v;
		send_idle_pct = idle_pct;
		stall_pct = stall_in_pct;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 9);
			case (r)
				0, 1:    kind = SEG_NOISE;
				2, 3:    kind = SEG_HOLD;
				4:       kind = SEG_EXTREME;
				5, 6:    kind = SEG_RAMP;
				default: kind = SEG_SMALL;
			endcase
			seg_len = (kind == SEG_EXTREME) ? $urandom_range(30, 90) : $urandom_range(4, 30);
			level = SW'($urandom);
			step = $signed(SW'($urandom_range(0, 131071))) - 24'sd65536;
			if (kind == SEG_EXTREME) begin
				extreme_high = !extreme_high;
				level = extreme_high ? S_MAX : S_MIN;
			end
			for (int j = 0; j < seg_len && sent < n; j++) begin
				case (kind)
					SEG_NOISE:   v = SW'($urandom);
					SEG_RAMP: begin
						level = level + step;
						v = level;
					end
					SEG_SMALL:   v = level + $signed(SW'($urandom_range(0, 511))) - 24'sd256;
					default:     v = level;
				endcase
				send_sample(v);
				sent++;
			end
		end
	endtask

	// output held off long enough that the filter stops taking requests
	task automatic test_backpressure;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 800;
		for (int i = 0; i < 16; i++)
			send_sample(SW'($urandom));
	endtask

	task automatic test_drain_pause;
		send_idle_pct = 0;
		stall_pct = 30;
		for (int i = 0; i < 10; i++)
			send_sample(SW'($urandom));
		wait_drain();
		repeat (20) @(posedge clk);
		for (int i = 0; i < 10; i++)
			send_sample(SW'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		requests_sent = 0;
		results_checked = 0;
		mismatches = 0;
		extreme_high = 1'b0;
		for (int k = 0; k < N_HIST; k++) begin
			x_delay[k] = 0;
			y_delay[k] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_saturation();
		test_random(125, 0, 0);
		test_random(125, 56, 0);
		test_random(125, 0, 56);
		test_random(125, 24, 24);
		test_backpressure();
		test_drain_pause();

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d requests: extremes, saturating steps, random segments",
			requests_sent);
		$display("four idle/stall mixes, hold-off and drain pause; %0d compared, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/iirlp_pkg.sv
rtl/iir_lowpass_order6.sv
test/iir_lowpass_order6_test.sv
